@@ rtl/calendar_date_day_number_macros.svh @@
// Assertion macros shared by the calendar date block.
`ifndef CALENDAR_DATE_DAY_NUMBER_MACROS_SVH
`define CALENDAR_DATE_DAY_NUMBER_MACROS_SVH

`ifndef SYNTH

// Check a condition at every clock edge outside reset.
`define CDDN_ASSERT(name, ck, rn, cond, msg) \
    name: assert property (@(posedge ck) disable iff (!rn) (cond)) else $error(msg);

// Check that a trigger is followed by a condition in the next cycle.
`define CDDN_ASSERT_NEXT(name, ck, rn, trig, cond, msg) \
    name: assert property (@(posedge ck) disable iff (!rn) (trig) |=> (cond)) else $error(msg);

`else

`define CDDN_ASSERT(name, ck, rn, cond, msg)
`define CDDN_ASSERT_NEXT(name, ck, rn, trig, cond, msg)

`endif

`endif

@@ rtl/cddn_pkg.sv @@
// Types, constants and month tables for the calendar date block.
package cddn_pkg;

    typedef logic [13:0] year_t;
    typedef logic [3:0]  month_t;
    typedef logic [4:0]  mday_t;
    typedef logic [22:0] count_t;
    typedef logic [8:0]  yday_t;

    // Load strobes for the three stages inside a date unit
    typedef struct packed {
        logic pre;
        logic year;
        logic count;
    } cddn_stage_en_t;

    localparam int YEAR_LIMIT = 10000;

    localparam month_t MONTH_JAN = 4'd1;
    localparam month_t MONTH_FEB = 4'd2;
    localparam month_t MONTH_DEC = 4'd12;

    // floor(x / 100) = (x * RECIP100) >> SHIFT100, exact for x below 43690
    localparam logic [12:0] RECIP100 = 13'd5243;
    localparam int          SHIFT100 = 19;

    // floor(x / 7) = (x * RECIP7) >> SHIFT7, exact for every 23-bit x
    localparam logic [23:0] RECIP7 = 24'd9586981;
    localparam int          SHIFT7 = 26;

    // Weekday anchor: 2018-09-09 is a Sunday
    localparam int REF_YEAR  = 2018;
    localparam int REF_DAY   = 365 * REF_YEAR + (REF_YEAR + 3) / 4 - (REF_YEAR + 99) / 100
                               + (REF_YEAR + 399) / 400 + 243 + 8;
    localparam int WD_OFFSET = (7 - REF_DAY % 7) % 7;

    // Days in a month of a common year
    function automatic mday_t month_len(input month_t m);
        mday_t len;
        unique case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                      len = 5'd30;
            4'd2:                                         len = 5'd28;
            default:                                      len = 5'd0;
        endcase
        return len;
    endfunction

    // Days of a common year before the first of a month
    function automatic yday_t days_before(input month_t m);
        yday_t n;
        unique case (m)
            4'd1:    n = 9'd0;
            4'd2:    n = 9'd31;
            4'd3:    n = 9'd59;
            4'd4:    n = 9'd90;
            4'd5:    n = 9'd120;
            4'd6:    n = 9'd151;
            4'd7:    n = 9'd181;
            4'd8:    n = 9'd212;
            4'd9:    n = 9'd243;
            4'd10:   n = 9'd273;
            4'd11:   n = 9'd304;
            4'd12:   n = 9'd334;
            default: n = 9'd0;
        endcase
        return n;
    endfunction

endpackage

@@ rtl/cddn_date.sv @@
// Three-stage date unit: checks one date and turns it into a day count.
module cddn_date
    import cddn_pkg::*;
(
    input  logic           clk,
    input  cddn_stage_en_t en,
    input  year_t          year,
    input  month_t         month,
    input  mday_t          day,
    output logic           date_ok,
    output count_t         day_count,
    output yday_t          day_index
);

    // Stage: reciprocal quotients and the year product
    year_t        y_reg;
    month_t       m_reg;
    mday_t        d_reg;
    logic [12:0]  q4_reg;
    logic [7:0]   q100c_reg;
    logic [5:0]   q400c_reg;
    logic [7:0]   qy_reg;
    count_t       m365_reg;

    logic [14:0]  sum99;
    logic [14:0]  sum399;
    logic [27:0]  prod100c;
    logic [25:0]  prod400c;
    logic [26:0]  prody;

    // Stage: leap rule, validity, year start and offset in year
    logic         ok_reg;
    count_t       ys_reg;
    yday_t        idx_reg;

    year_t        r100;
    logic         leap;
    mday_t        mlen;
    logic         ok_next;
    count_t       ys_next;
    yday_t        idx_next;

    // Stage: final day count
    logic         ok2_reg;
    count_t       cnt_reg;
    yday_t        idx2_reg;

    // Divide the shifted years by 4, 100 and 400
    always_comb
    begin
        sum99    = {1'b0, year} + 15'd99;
        sum399   = {1'b0, year} + 15'd399;
        prod100c = {13'd0, sum99} * {15'd0, RECIP100};
        prod400c = {13'd0, sum399[14:2]} * {13'd0, RECIP100};
        prody    = {13'd0, year} * {14'd0, RECIP100};
    end

    always_ff @(posedge clk)
    begin
        if (en.pre)
        begin
            y_reg     <= year;
            m_reg     <= month;
            d_reg     <= day;
            q4_reg    <= 13'(({1'b0, year} + 15'd3) >> 2);
            q100c_reg <= prod100c[SHIFT100 +: 8];
            q400c_reg <= prod400c[SHIFT100 +: 6];
            qy_reg    <= prody[SHIFT100 +: 8];
            m365_reg  <= {9'd0, year} * 23'd365;
        end
    end

    // Apply the leap rule and check the date
    always_comb
    begin
        r100     = y_reg - ({6'd0, qy_reg} * 14'd100);
        leap     = ((y_reg[1:0] == 2'd0) && (r100 != 14'd0))
                   || ((r100 == 14'd0) && (qy_reg[1:0] == 2'd0));
        mlen     = month_len(m_reg) + {4'd0, leap && (m_reg == MONTH_FEB)};
        ok_next  = (int'(y_reg) < YEAR_LIMIT) && (m_reg >= MONTH_JAN)
                   && (m_reg <= MONTH_DEC) && (d_reg != 5'd0) && (d_reg <= mlen);
        ys_next  = m365_reg + {10'd0, q4_reg} - {15'd0, q100c_reg} + {17'd0, q400c_reg};
        idx_next = days_before(m_reg) + {4'd0, d_reg} - 9'd1
                   + {8'd0, leap && (m_reg > MONTH_FEB)};
    end

    always_ff @(posedge clk)
    begin
        if (en.year)
        begin
            ok_reg  <= ok_next;
            ys_reg  <= ys_next;
            idx_reg <= idx_next;
        end
    end

    // Add the offset in the year to the year start
    always_ff @(posedge clk)
    begin
        if (en.count)
        begin
            ok2_reg  <= ok_reg;
            cnt_reg  <= ys_reg + {14'd0, idx_reg};
            idx2_reg <= idx_reg;
        end
    end

    assign date_ok   = ok2_reg;
    assign day_count = cnt_reg;
    assign day_index = idx2_reg;

endmodule

@@ rtl/calendar_date_day_number.sv @@
// Throughput: one date pair per cycle unless m_axis stalls, through a six-register
// pipeline; the reciprocal multipliers for the divisions by 100, 400 and 7
// set the stage depth. Each stage holds its own valid bit, so bubbles close up
// under output stalls. Reset (rst_n low, asynchronous) clears only the valid bits;
// no clearing pass.
`include "calendar_date_day_number_macros.svh"

module calendar_date_day_number
    import cddn_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // year_a[13:0], month_a[17:14], day_a[22:18], year_b[36:23], month_b[40:37],
    // day_b[45:41], zero [47:46]
    input  logic [47:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // dates_valid[0], day_number[22:1], weekday[25:23], day_of_year[34:26],
    // span_days[56:35], zero [63:57]
    output logic [63:0] m_axis_tdata
);

    logic [5:0]     valid_reg;
    logic [5:0]     valid_next;
    logic [5:0]     ld;
    logic [5:0]     drain;
    cddn_stage_en_t date_en;

    // Input register
    year_t          ya_reg;
    month_t         ma_reg;
    mday_t          da_reg;
    year_t          yb_reg;
    month_t         mb_reg;
    mday_t          db_reg;

    logic           ok_a;
    logic           ok_b;
    count_t         na;
    count_t         nb;
    yday_t          idx_a;
    yday_t          idx_b;
    yday_t          idx_unused;

    // Span and weekday stage
    count_t         diff;
    count_t         wd_x;
    logic [46:0]    prod7;
    logic           ok5_reg;
    logic [21:0]    na5_reg;
    count_t         wd_x_reg;
    logic [20:0]    q7_reg;
    yday_t          yday_reg;
    logic [21:0]    span_reg;

    // Output register
    count_t         wd_rem;
    logic [63:0]    out_data_reg;

    // Pass a word forward where the next stage is empty or moving on
    always_comb
    begin
        ld[5]         = valid_reg[4] && (!valid_reg[5] || m_axis_tready);
        ld[4]         = valid_reg[3] && (!valid_reg[4] || ld[5]);
        ld[3]         = valid_reg[2] && (!valid_reg[3] || ld[4]);
        ld[2]         = valid_reg[1] && (!valid_reg[2] || ld[3]);
        ld[1]         = valid_reg[0] && (!valid_reg[1] || ld[2]);
        s_axis_tready = !valid_reg[0] || ld[1];
        ld[0]         = s_axis_tvalid && s_axis_tready;
        drain         = {m_axis_tready, ld[5:1]};
        valid_next    = ld | (valid_reg & ~drain);
        date_en.pre   = ld[1];
        date_en.year  = ld[2];
        date_en.count = ld[3];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 6'd0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign m_axis_tvalid = valid_reg[5];

    // Capture the input word
    always_ff @(posedge clk)
    begin
        if (ld[0])
        begin
            ya_reg <= s_axis_tdata[13:0];
            ma_reg <= s_axis_tdata[17:14];
            da_reg <= s_axis_tdata[22:18];
            yb_reg <= s_axis_tdata[36:23];
            mb_reg <= s_axis_tdata[40:37];
            db_reg <= s_axis_tdata[45:41];
        end
    end

    cddn_date u_date_a (
        .clk       (clk),
        .en        (date_en),
        .year      (ya_reg),
        .month     (ma_reg),
        .day       (da_reg),
        .date_ok   (ok_a),
        .day_count (na),
        .day_index (idx_a)
    );

    cddn_date u_date_b (
        .clk       (clk),
        .en        (date_en),
        .year      (yb_reg),
        .month     (mb_reg),
        .day       (db_reg),
        .date_ok   (ok_b),
        .day_count (nb),
        .day_index (idx_b)
    );

    // Span between the dates and the quotient for the weekday
    always_comb
    begin
        diff       = (na >= nb) ? (na - nb) : (nb - na);
        wd_x       = na + 23'(WD_OFFSET);
        prod7      = {24'd0, wd_x} * {23'd0, RECIP7};
        idx_unused = idx_b;
    end

    always_ff @(posedge clk)
    begin
        if (ld[4])
        begin
            ok5_reg  <= ok_a && ok_b && (idx_unused == idx_b);
            na5_reg  <= na[21:0];
            wd_x_reg <= wd_x;
            q7_reg   <= prod7[SHIFT7 +: 21];
            yday_reg <= idx_a + 9'd1;
            span_reg <= 22'(diff + 23'd1);
        end
    end

    // Finish the weekday and zero the word when a date is invalid
    always_comb
    begin
        wd_rem = wd_x_reg - ({2'd0, q7_reg} * 23'd7);
    end

    always_ff @(posedge clk)
    begin
        if (ld[5])
        begin
            if (ok5_reg)
            begin
                out_data_reg <= {7'd0, span_reg, yday_reg, wd_rem[2:0], na5_reg, 1'b1};
            end
            else
            begin
                out_data_reg <= 64'd0;
            end
        end
    end

    assign m_axis_tdata = out_data_reg;

    // Checks on the pipeline and the result word
    `CDDN_ASSERT(a_full_when_stalled, clk, rst_n, s_axis_tready || (&valid_reg), "input stalled with a free stage")
    `CDDN_ASSERT_NEXT(a_accept_fills, clk, rst_n, s_axis_tvalid && s_axis_tready, valid_reg[0], "accepted word not captured")
    `CDDN_ASSERT(a_invalid_zero, clk, rst_n, !m_axis_tvalid || m_axis_tdata[0] || (m_axis_tdata == 64'd0), "invalid dates with nonzero results")
    `CDDN_ASSERT(a_weekday_range, clk, rst_n, !m_axis_tvalid || (m_axis_tdata[25:23] != 3'd7), "weekday out of range")

endmodule
